FILE: hw/rtl/rfd_pkg.sv
// Shared types, constants and the CRC-16 step for the receive frame deframer.
package rfd_pkg;

  localparam int CAPACITY       = 256;
  localparam int MAX_MARK_BYTES = 4;
  localparam int MARKS          = (MAX_MARK_BYTES < 4) ? MAX_MARK_BYTES : 4;
  localparam int AW             = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW             = $clog2(CAPACITY + 1);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] PH_INIT  = 3'd0;
  localparam logic [2:0] PH_IDLE  = 3'd1;
  localparam logic [2:0] PH_HEAD  = 3'd2;
  localparam logic [2:0] PH_RCV   = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  localparam logic [2:0] EV_READY = 3'd0;
  localparam logic [2:0] EV_FRAME = 3'd1;
  localparam logic [2:0] EV_CRC   = 3'd2;
  localparam logic [2:0] EV_OVER  = 3'd3;
  localparam logic [2:0] EV_READ  = 3'd4;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [2:0] CFG_END_BY_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_HEAD_LENGTH    = 3'd1;
  localparam logic [2:0] CFG_HEAD_PATTERN   = 3'd2;
  localparam logic [2:0] CFG_TAIL_LENGTH    = 3'd3;
  localparam logic [2:0] CFG_TAIL_PATTERN   = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT_TICKS  = 3'd5;
  localparam logic [2:0] CFG_CRC_CHECK      = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [8:0] frame_length;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic       vld;
    out_item_t  item;
  } res_t;

  // Modbus CRC-16, reflected polynomial, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: hw/rtl/rfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rfd_front.sv
// Front end: configuration, frame state machine, frame store and result staging.
module rfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  rfd_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output rfd_pkg::res_t     res
);

  // Configuration registers
  logic        end_by_timeout_r;
  logic [2:0]  head_length_r;
  logic [31:0] head_pattern_r;
  logic [2:0]  tail_length_r;
  logic [31:0] tail_pattern_r;
  logic [15:0] timeout_ticks_r;
  logic        crc_check_r;

  // Frame state
  logic [2:0]             ph_r, ph_nxt;
  logic [rfd_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]            last_r, last_nxt;
  logic [15:0]            crc_r   [rfd_pkg::MARKS+1];
  logic [15:0]            crc_nxt [rfd_pkg::MARKS+1];
  logic [15:0]            sil_r, sil_nxt;
  logic                   run_r, run_nxt;
  logic [rfd_pkg::CW-1:0] done_r, done_nxt;

  // Byte push, computed once from the pre-cleared or current state
  logic                   pre_clear;
  logic [rfd_pkg::CW-1:0] base_cnt, p_cnt;
  logic [31:0]            p_last;
  logic [15:0]            base_crc0;
  logic [15:0]            p_crc [rfd_pkg::MARKS+1];

  logic [2:0]             hl, tl;
  logic [15:0]            limit, sil_inc;
  logic [7:0]             head_byte;
  logic                   tail_hit;
  logic                   res_v;
  logic [2:0]             ev;
  logic                   we;
  logic                   rd_ok;

  // Stage B
  logic                   b_vld_r;
  logic [2:0]             b_ev_r;
  logic [8:0]             b_len_r;
  logic                   b_rd_r;
  logic [7:0]             ram_q;

  assign hl = (32'(head_length_r) > rfd_pkg::MARKS) ? 3'(rfd_pkg::MARKS) : head_length_r;
  assign tl = (32'(tail_length_r) > rfd_pkg::MARKS) ? 3'(rfd_pkg::MARKS) : tail_length_r;
  assign limit = (timeout_ticks_r == 16'd0) ? 16'd1 : timeout_ticks_r;
  assign sil_inc = (sil_r != 16'hFFFF) ? sil_r + 16'd1 : sil_r;

  assign pre_clear = (ph_r == rfd_pkg::PH_IDLE) ||
                     ((ph_r == rfd_pkg::PH_ERROR) && !end_by_timeout_r);
  assign base_cnt  = pre_clear ? '0 : cnt_r;
  assign base_crc0 = pre_clear ? 16'hFFFF : crc_r[0];
  assign p_cnt     = base_cnt + 1'b1;
  assign p_last    = {in_item.data_byte, last_r[31:8]};

  always_comb begin
    p_crc[0] = rfd_pkg::crc16_byte(base_crc0, in_item.data_byte);
    for (int k = 1; k <= rfd_pkg::MARKS; k++) begin
      p_crc[k] = pre_clear ? 16'hFFFF : crc_r[k-1];
    end
  end

  // Head byte expected at the position just pushed
  always_comb begin
    case (p_cnt[1:0] - 2'd1)
      2'd0:    head_byte = head_pattern_r[7:0];
      2'd1:    head_byte = head_pattern_r[15:8];
      2'd2:    head_byte = head_pattern_r[23:16];
      default: head_byte = head_pattern_r[31:24];
    endcase
  end

  // Tail compare against the newest stored bytes after the push
  always_comb begin
    case (tl)
      3'd1:    tail_hit = (p_last[31:24] == tail_pattern_r[7:0]);
      3'd2:    tail_hit = (p_last[31:16] == tail_pattern_r[15:0]);
      3'd3:    tail_hit = (p_last[31:8]  == tail_pattern_r[23:0]);
      3'd4:    tail_hit = (p_last == tail_pattern_r);
      default: tail_hit = 1'b0;
    endcase
  end

  always_comb begin
    logic stop;
    logic pushed;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    crc_nxt  = crc_r;
    sil_nxt  = sil_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    res_v    = 1'b0;
    ev       = rfd_pkg::EV_READY;
    we       = 1'b0;
    rd_ok    = 1'b0;
    stop     = 1'b0;
    pushed   = 1'b0;
    if (acc) begin
      case (in_item.kind)
        rfd_pkg::KIND_BYTE: begin
          if (ph_r == rfd_pkg::PH_INIT) begin
            stop = 1'b1;
            if (end_by_timeout_r) begin
              run_nxt = 1'b1;
              sil_nxt = '0;
            end else begin
              ph_nxt = rfd_pkg::PH_IDLE;
              res_v  = 1'b1;
              ev     = rfd_pkg::EV_READY;
            end
          end else if ((ph_r == rfd_pkg::PH_ERROR) && end_by_timeout_r) begin
            stop    = 1'b1;
            run_nxt = 1'b1;
            sil_nxt = '0;
          end else if (pre_clear) begin
            pushed = 1'b1;
            if ((hl != 3'd0) && (in_item.data_byte != head_pattern_r[7:0])) begin
              stop = 1'b1;
            end else begin
              if (hl == 3'd2 || hl == 3'd3 || hl == 3'd4) begin
                ph_nxt = rfd_pkg::PH_HEAD;
              end else begin
                ph_nxt = rfd_pkg::PH_RCV;
              end
              if (end_by_timeout_r) begin
                run_nxt = 1'b1;
                sil_nxt = '0;
              end
            end
          end else if (ph_r == rfd_pkg::PH_HEAD) begin
            pushed = 1'b1;
            if (in_item.data_byte != head_byte) begin
              ph_nxt = rfd_pkg::PH_IDLE;
              stop   = 1'b1;
            end else begin
              if (p_cnt >= rfd_pkg::CW'(hl)) begin
                ph_nxt = rfd_pkg::PH_RCV;
              end
              if (end_by_timeout_r) begin
                run_nxt = 1'b1;
                sil_nxt = '0;
              end
            end
          end else if (ph_r == rfd_pkg::PH_RCV) begin
            if (cnt_r >= rfd_pkg::CW'(rfd_pkg::CAPACITY)) begin
              ph_nxt = rfd_pkg::PH_ERROR;
              res_v  = 1'b1;
              ev     = rfd_pkg::EV_OVER;
              stop   = 1'b1;
            end else begin
              pushed = 1'b1;
            end
          end else begin
            ph_nxt = rfd_pkg::PH_IDLE;
            stop   = 1'b1;
          end

          if (pushed) begin
            we       = (base_cnt < rfd_pkg::CW'(rfd_pkg::CAPACITY));
            cnt_nxt  = p_cnt;
            last_nxt = p_last;
            crc_nxt  = p_crc;
            // A completed head is discarded before the payload starts.
            if (!stop && (ph_r != rfd_pkg::PH_RCV) && (ph_nxt == rfd_pkg::PH_RCV) &&
                (hl != 3'd0)) begin
              cnt_nxt = '0;
              for (int k = 0; k <= rfd_pkg::MARKS; k++) begin
                crc_nxt[k] = 16'hFFFF;
              end
            end
          end

          if (!stop && (ph_nxt == rfd_pkg::PH_RCV)) begin
            if (end_by_timeout_r) begin
              run_nxt = 1'b1;
              sil_nxt = '0;
            end else if ((tl != 3'd0) && (cnt_nxt >= rfd_pkg::CW'(tl)) && tail_hit) begin
              cnt_nxt = cnt_nxt - rfd_pkg::CW'(tl);
              ph_nxt  = rfd_pkg::PH_IDLE;
              if (cnt_nxt != '0) begin
                res_v = 1'b1;
                if (crc_check_r && (crc_nxt[tl] != 16'h0000)) begin
                  ev = rfd_pkg::EV_CRC;
                end else begin
                  ev       = rfd_pkg::EV_FRAME;
                  done_nxt = cnt_nxt;
                end
              end
            end
          end
        end
        rfd_pkg::KIND_TICK: begin
          if (end_by_timeout_r && run_r) begin
            sil_nxt = sil_inc;
            if (sil_inc >= limit) begin
              if (ph_r == rfd_pkg::PH_INIT) begin
                res_v = 1'b1;
                ev    = rfd_pkg::EV_READY;
              end else if (ph_r == rfd_pkg::PH_RCV) begin
                if (cnt_r != '0) begin
                  res_v = 1'b1;
                  if (crc_check_r && (crc_r[0] != 16'h0000)) begin
                    ev = rfd_pkg::EV_CRC;
                  end else begin
                    ev       = rfd_pkg::EV_FRAME;
                    done_nxt = cnt_r;
                  end
                end
              end else if (ph_r == rfd_pkg::PH_ERROR) begin
                res_v = 1'b1;
                ev    = rfd_pkg::EV_OVER;
              end
              ph_nxt  = rfd_pkg::PH_IDLE;
              run_nxt = 1'b0;
              sil_nxt = '0;
            end
          end
        end
        rfd_pkg::KIND_READ: begin
          res_v = 1'b1;
          ev    = rfd_pkg::EV_READ;
          rd_ok = (32'(in_item.read_index) < rfd_pkg::CAPACITY);
        end
        default: begin
        end
      endcase
    end
    // Switching the end mode restarts the search; stored data is kept.
    if (cfg_we && (cfg_index == rfd_pkg::CFG_END_BY_TIMEOUT)) begin
      ph_nxt  = cfg_data[0] ? rfd_pkg::PH_INIT : rfd_pkg::PH_IDLE;
      run_nxt = cfg_data[0];
      sil_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_by_timeout_r <= 1'b0;
      head_length_r    <= 3'd0;
      head_pattern_r   <= 32'd0;
      tail_length_r    <= 3'd1;
      tail_pattern_r   <= 32'd10;
      timeout_ticks_r  <= 16'd10;
      crc_check_r      <= 1'b0;
      ph_r             <= rfd_pkg::PH_IDLE;
      cnt_r            <= '0;
      last_r           <= '0;
      for (int k = 0; k <= rfd_pkg::MARKS; k++) begin
        crc_r[k] <= 16'hFFFF;
      end
      sil_r            <= '0;
      run_r            <= 1'b0;
      done_r           <= '0;
      b_vld_r          <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      crc_r   <= crc_nxt;
      sil_r   <= sil_nxt;
      run_r   <= run_nxt;
      done_r  <= done_nxt;
      b_vld_r <= res_v;
      if (cfg_we) begin
        case (cfg_index)
          rfd_pkg::CFG_END_BY_TIMEOUT: end_by_timeout_r <= cfg_data[0];
          rfd_pkg::CFG_HEAD_LENGTH:   head_length_r   <= cfg_data[2:0];
          rfd_pkg::CFG_HEAD_PATTERN:  head_pattern_r  <= cfg_data;
          rfd_pkg::CFG_TAIL_LENGTH:   tail_length_r   <= cfg_data[2:0];
          rfd_pkg::CFG_TAIL_PATTERN:  tail_pattern_r  <= cfg_data;
          rfd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[15:0];
          rfd_pkg::CFG_CRC_CHECK:     crc_check_r     <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    b_ev_r  <= ev;
    b_len_r <= 9'(done_nxt);
    b_rd_r  <= rd_ok;
  end

  rfd_ram #(
    .WIDTH (8),
    .DEPTH (rfd_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (rfd_pkg::AW'(base_cnt)),
    .wdata (in_item.data_byte),
    .raddr (rfd_pkg::AW'(in_item.read_index)),
    .rdata (ram_q)
  );

  assign res.vld                = b_vld_r;
  assign res.item.event_res     = b_ev_r;
  assign res.item.frame_length  = b_len_r;
  assign res.item.read_byte     = b_rd_r ? ram_q : 8'd0;

`ifndef SYNTH
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.kind == rfd_pkg::KIND_READ) |=>
      (b_vld_r && b_ev_r == rfd_pkg::EV_READ))
    else $error("read item did not produce a read result");
  a_timer_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !end_by_timeout_r |-> !run_r)
    else $error("silence timer running in marker mode");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rfd_pkg::CW'(rfd_pkg::CAPACITY))
    else $error("stored count beyond capacity");
  a_overflow_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.kind == rfd_pkg::KIND_BYTE && ph_r == rfd_pkg::PH_RCV &&
     cnt_r >= rfd_pkg::CW'(rfd_pkg::CAPACITY) && !cfg_we) |=>
      (ph_r == rfd_pkg::PH_ERROR && b_ev_r == rfd_pkg::EV_OVER))
    else $error("overflow byte did not enter error phase");
`endif

endmodule

FILE: hw/rtl/rfd_queue.sv
// Result queue between the frame logic and the result port.
module rfd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rfd_pkg::res_t           res,
  input  logic                    pop,
  output logic                    empty,
  output rfd_pkg::out_item_t      item,
  output logic [rfd_pkg::QLW-1:0] level
);

  rfd_pkg::out_item_t      q_mem [rfd_pkg::QDEPTH];
  logic [rfd_pkg::QAW-1:0] wp_r, rp_r;
  logic [rfd_pkg::QLW-1:0] lvl_r;
  logic                    do_pop;

  assign empty  = (lvl_r == '0);
  assign do_pop = pop && !empty;
  assign item   = q_mem[rp_r];
  assign level  = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (res.vld) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      lvl_r <= lvl_r + rfd_pkg::QLW'(res.vld) - rfd_pkg::QLW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      q_mem[wp_r] <= res.item;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (lvl_r < rfd_pkg::QLW'(rfd_pkg::QDEPTH)))
    else $error("result queue overrun");
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!res.vld && !do_pop) |=> $stable(lvl_r))
    else $error("queue level changed without push or pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_r == '0) |-> (wp_r == rp_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

FILE: hw/rtl/rx_frame_deframer_top.sv
// Top level of the receive frame deframer.
//
//  channel | handshake                 | payload
//  input   | in_push / in_full         | in_item (kind, data_byte, read_index)
//  result  | out_pop / out_empty       | out_item (event_res, frame_length, read_byte)
//  config  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item is accepted per cycle while in_full is low; its result, if any, reaches the queue in the next cycle.
// The rate is set by the frame state update and one store port.
// in_full rises when the four-entry result queue plus the result in flight fill it.
// cfg_ready is always high. Reset is synchronous; the frame store is not cleared.
module rx_frame_deframer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rfd_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rfd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  rfd_pkg::res_t           res;
  logic [rfd_pkg::QLW-1:0] level;
  logic                    acc;

  assign cfg_ready = 1'b1;
  assign in_full   = (32'(level) + 32'(res.vld)) >= rfd_pkg::QDEPTH;
  assign acc       = in_push && !in_full;

  rfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  rfd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .item  (out_item),
    .level (level)
  );

endmodule

FILE: test/rx_frame_deframer_checker.sv
// Checker for the receive frame deframer: predicts each result and compares it.
`timescale 1ns / 100ps
module rx_frame_deframer_checker
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  in_item_t    in_item,
  input  logic        out_empty,
  input  logic        out_pop,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Programmed registers.
  logic        by_silence;
  logic [2:0]  head_len;
  logic [31:0] head_pat;
  logic [2:0]  tail_len;
  logic [31:0] tail_pat;
  logic [15:0] silence_limit;
  logic        crc_on;

  // Frame recovery state.
  logic [2:0]  rx_state;
  logic [7:0]  payload_mem [CAPACITY];
  int          fill;
  logic [31:0] recent;
  logic [15:0] crc_hist [MARKS+1];
  int          quiet_ticks;
  logic        timer_on;
  logic [8:0]  last_len;

  out_item_t   result_q [$];

  function automatic logic [15:0] modbus_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (x[0]) x = (x >> 1) ^ 16'hA001;
      else x = x >> 1;
    end
    return x;
  endfunction

  function automatic int clip_marks(int n);
    return (n > MARKS) ? MARKS : n;
  endfunction

  task automatic restart_store();
    fill = 0;
    for (int k = 0; k <= MARKS; k++) crc_hist[k] = 16'hFFFF;
  endtask

  task automatic take_byte(logic [7:0] b);
    if (fill < CAPACITY) payload_mem[fill] = b;
    fill++;
    recent = {b, recent[31:8]};
    for (int k = MARKS; k > 0; k--) crc_hist[k] = crc_hist[k-1];
    crc_hist[0] = modbus_step(crc_hist[0], b);
  endtask

  task automatic rearm_timer();
    if (by_silence) begin
      timer_on = 1'b1;
      quiet_ticks = 0;
    end
  endtask

  task automatic close_frame(int len, logic [15:0] c, output int ev);
    if (len == 0) ev = -1;
    else if (crc_on && c != 16'h0000) ev = EV_CRC;
    else begin
      last_len = len[8:0];
      ev = EV_FRAME;
    end
  endtask

  task automatic byte_event(logic [7:0] b, output int ev);
    int hl, idx, t;
    logic [63:0] m;
    logic [31:0] got;
    ev = -1;
    hl = clip_marks(int'(head_len));
    if (rx_state == PH_INIT) begin
      if (by_silence) rearm_timer();
      else begin
        rx_state = PH_IDLE;
        ev = EV_READY;
      end
      return;
    end
    if (rx_state == PH_ERROR && by_silence) begin
      rearm_timer();
      return;
    end
    if (rx_state == PH_ERROR || rx_state == PH_IDLE) begin
      restart_store();
      take_byte(b);
      if (hl > 0) begin
        if (b != head_pat[7:0]) return;
        if (hl == 1) begin
          restart_store();
          rx_state = PH_RCV;
        end else rx_state = PH_HEAD;
      end else rx_state = PH_RCV;
      rearm_timer();
    end else if (rx_state == PH_HEAD) begin
      take_byte(b);
      idx = (fill - 1) & 3;
      if (b != head_pat[8*idx +: 8]) begin
        rx_state = PH_IDLE;
        return;
      end
      if (fill >= hl) begin
        restart_store();
        rx_state = PH_RCV;
      end
      rearm_timer();
    end else if (rx_state == PH_RCV) begin
      if (fill >= CAPACITY) begin
        rx_state = PH_ERROR;
        ev = EV_OVER;
        return;
      end
      take_byte(b);
    end else begin
      rx_state = PH_IDLE;
      return;
    end
    if (rx_state != PH_RCV) return;
    if (by_silence) begin
      rearm_timer();
      return;
    end
    t = clip_marks(int'(tail_len));
    if (t == 0 || fill < t) return;
    m = (64'd1 << (8 * t)) - 64'd1;
    got = recent >> (32 - 8 * t);
    if ((got & m[31:0]) != (tail_pat & m[31:0])) return;
    fill -= t;
    rx_state = PH_IDLE;
    close_frame(fill, crc_hist[t], ev);
  endtask

  task automatic tick_event(output int ev);
    int lim;
    ev = -1;
    lim = (silence_limit == 16'd0) ? 1 : int'(silence_limit);
    if (!by_silence || !timer_on) return;
    if (quiet_ticks < 65535) quiet_ticks++;
    if (quiet_ticks < lim) return;
    if (rx_state == PH_INIT) ev = EV_READY;
    else if (rx_state == PH_RCV) close_frame(fill, crc_hist[0], ev);
    else if (rx_state == PH_ERROR) ev = EV_OVER;
    rx_state = PH_IDLE;
    timer_on = 1'b0;
    quiet_ticks = 0;
  endtask

  task automatic predict_item(in_item_t it);
    int ev;
    logic [7:0] rd;
    out_item_t r;
    ev = -1;
    rd = 8'h00;
    case (it.kind)
      KIND_BYTE: byte_event(it.data_byte, ev);
      KIND_TICK: tick_event(ev);
      KIND_READ: begin
        rd = payload_mem[it.read_index];
        ev = EV_READ;
      end
      default: ev = -1;
    endcase
    if (ev >= 0) begin
      r.event_res = ev[2:0];
      r.frame_length = last_len;
      r.read_byte = rd;
      result_q.push_back(r);
    end
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] v);
    case (idx)
      CFG_END_BY_TIMEOUT: begin
        by_silence = v[0];
        rx_state = v[0] ? PH_INIT : PH_IDLE;
        timer_on = v[0];
        quiet_ticks = 0;
      end
      CFG_HEAD_LENGTH:   head_len = v[2:0];
      CFG_HEAD_PATTERN:  head_pat = v;
      CFG_TAIL_LENGTH:   tail_len = v[2:0];
      CFG_TAIL_PATTERN:  tail_pat = v;
      CFG_TIMEOUT_TICKS: silence_limit = v[15:0];
      CFG_CRC_CHECK:     crc_on = v[0];
      default: ;
    endcase
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (result_q.size() == 0) begin
      $error("unexpected result: event_res %0d frame_length %0d read_byte %0d",
             got.event_res, got.frame_length, got.read_byte);
      fail_count++;
      return;
    end
    want = result_q.pop_front();
    if (got.event_res !== want.event_res) begin
      $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
      fail_count++;
    end
    if (got.frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
      fail_count++;
    end
    if (got.read_byte !== want.read_byte) begin
      $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      by_silence = 1'b0;
      head_len = 3'd0;
      head_pat = 32'd0;
      tail_len = 3'd1;
      tail_pat = 32'd10;
      silence_limit = 16'd10;
      crc_on = 1'b0;
      rx_state = PH_IDLE;
      restart_store();
      recent = 32'd0;
      quiet_ticks = 0;
      timer_on = 1'b0;
      last_len = 9'd0;
      result_q.delete();
    end else begin
      if (out_pop && !out_empty) compare_result(out_item);
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_push && !in_full) predict_item(in_item);
    end
    pending = result_q.size();
  end

endmodule

FILE: test/rx_frame_deframer_top_tb.sv
// Testbench top for the receive frame deframer: stimulus, idling and the verdict.
`timescale 1ns / 100ps
module rx_frame_deframer_top_tb;
  import rfd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_item_t    in_item = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  int          fail_count;
  int          pending;

  // Copy of the programmed settings, used to shape well-formed frames.
  logic        mode_silence;
  logic [2:0]  mode_head_len;
  logic [31:0] mode_head_pat;
  logic [2:0]  mode_tail_len;
  logic [31:0] mode_tail_pat;
  logic [15:0] mode_ticks;
  logic        mode_crc;

  bit quiet = 1'b0;
  int gap_left = 0;
  int sent = 0;
  int dog = 0;

  rx_frame_deframer_top uut (.*);

  rx_frame_deframer_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: pops with random stall bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        if (!quiet && $urandom_range(0, 15) == 0) stall = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) || !rst_n)
      dog <= 0;
    else if (dog >= 3000) begin
      $display("TEST FAILED");
      $finish;
    end else dog <= dog + 1;
  end

  function automatic logic [15:0] crc_of(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic put(logic [1:0] k, logic [7:0] d, logic [7:0] ri);
    in_item_t it;
    it.kind = k;
    it.data_byte = d;
    it.read_index = ri;
    if (!quiet && $urandom_range(0, 15) == 0) gap_left = $urandom_range(1, 19);
    if (gap_left > 0) begin
      in_push <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_item <= it;
    in_push <= 1'b1;
    do @(negedge clk); while (in_full);
    @(posedge clk);
    sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    put(KIND_BYTE, b, 8'($urandom));
  endtask

  task automatic put_tick();
    put(KIND_TICK, 8'($urandom), 8'($urandom));
  endtask

  // Registers change only once every expected result has come out.
  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic s, logic [2:0] hl, logic [31:0] hp, logic [2:0] tl,
                       logic [31:0] tp, logic [15:0] tk, logic cc);
    reg_write(CFG_HEAD_LENGTH, 32'(hl));
    reg_write(CFG_HEAD_PATTERN, hp);
    reg_write(CFG_TAIL_LENGTH, 32'(tl));
    reg_write(CFG_TAIL_PATTERN, tp);
    reg_write(CFG_TIMEOUT_TICKS, 32'(tk));
    reg_write(CFG_CRC_CHECK, 32'(cc));
    reg_write(CFG_END_BY_TIMEOUT, 32'(s));
    mode_silence = s;
    mode_head_len = hl;
    mode_head_pat = hp;
    mode_tail_len = tl;
    mode_tail_pat = tp;
    mode_ticks = tk;
    mode_crc = cc;
  endtask

  // A frame shaped for the current settings, with an occasional broken part.
  task automatic send_frame();
    int hl, tl, plen, lim;
    logic [7:0] b;
    logic [15:0] c;
    hl = (mode_head_len > 4) ? 4 : int'(mode_head_len);
    tl = (mode_tail_len > 4) ? 4 : int'(mode_tail_len);
    lim = (mode_ticks == 0) ? 1 : int'(mode_ticks);
    for (int i = 0; i < hl; i++) begin
      b = mode_head_pat[8*i +: 8];
      if ($urandom_range(0, 24) == 0) b = b ^ 8'h01;
      put_byte(b);
    end
    plen = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 10);
    c = 16'hFFFF;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      put_byte(b);
      c = crc_of(c, b);
    end
    if (mode_crc && plen > 0) begin
      if ($urandom_range(0, 5) == 0) c = c ^ 16'h0001;
      put_byte(c[7:0]);
      put_byte(c[15:8]);
    end
    if (mode_silence) repeat (lim + $urandom_range(0, 1)) put_tick();
    else for (int i = 0; i < tl; i++) put_byte(mode_tail_pat[8*i +: 8]);
  endtask

  initial begin
    int mark, lim;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    mode_silence = 1'b0;
    mode_head_len = 3'd0;
    mode_tail_len = 3'd1;
    mode_tail_pat = 32'd10;
    mode_ticks = 16'd10;
    mode_crc = 1'b0;

    // Fill every store entry so that any later read is of written data,
    // then push one byte past the end for an overflow.
    for (int i = 0; i < CAPACITY; i++) put_byte((i[7:0] == 8'h0A) ? 8'h0B : i[7:0]);
    put_byte(8'h33);
    put_byte(8'h0A);

    put(KIND_READ, 8'h00, 8'h00);
    put(KIND_READ, 8'hFF, 8'hFF);
    put(2'd3, 8'hFF, 8'hFF);
    put_tick();
    put_byte(8'h01); put_byte(8'h02); put_byte(8'h0A);
    put_byte(8'h0A);

    setup(1'b0, 3'd0, 32'd0, 3'd1, 32'h0A, 16'd10, 1'b1);
    put_byte(8'h11); put_byte(8'h22); put_byte(8'h7F); put_byte(8'h1D); put_byte(8'h0A);
    put_byte(8'h11); put_byte(8'h22); put_byte(8'h33); put_byte(8'h0A);

    setup(1'b0, 3'd2, 32'h0000A55A, 3'd4, 32'h0D0A0D0A, 16'd10, 1'b0);
    put_byte(8'h77);
    put_byte(8'h5A); put_byte(8'h77);
    put_byte(8'h5A); put_byte(8'hA5); put_byte(8'h10); put_byte(8'h20);
    put_byte(8'h0A); put_byte(8'h0D); put_byte(8'h0A); put_byte(8'h0D);

    setup(1'b0, 3'd7, 32'hFFFFFFFF, 3'd0, 32'hFFFFFFFF, 16'd65535, 1'b0);
    for (int i = 0; i < 6; i++) put_byte(8'hFF);

    // Silence mode with a zero limit, which behaves as a limit of one.
    setup(1'b1, 3'd0, 32'd0, 3'd7, 32'd0, 16'd0, 1'b0);
    put_byte(8'h00); put_tick();
    put_byte(8'h01); put_byte(8'h02); put_tick(); put_tick();

    setup(1'b1, 3'd0, 32'd0, 3'd1, 32'd0, 16'd65535, 1'b0);
    put_byte(8'h44); put_tick(); put_tick();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph == 11);
      if (ph == 0)
        setup(1'b0, 3'd4, 32'hFFFFFFFF, 3'd4, 32'hFFFFFFFF, 16'd6, 1'b1);
      else if (ph == 1)
        setup(1'b1, 3'd4, 32'h00000000, 3'd0, 32'd0, 16'd1, 1'b1);
      else
        setup(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
              3'($urandom_range(0, 7)), $urandom, 16'($urandom_range(0, 6)),
              1'($urandom_range(0, 1)));
      lim = (mode_ticks == 0) ? 1 : int'(mode_ticks);
      if (mode_silence) repeat (lim) put_tick();
      mark = sent;
      while (sent - mark < 90) begin
        case ($urandom_range(0, 9))
          7, 8: put(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
          9: put(KIND_READ, 8'($urandom), 8'($urandom));
          default: send_frame();
        endcase
      end
    end

    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_ram.sv
hw/rtl/rfd_front.sv
hw/rtl/rfd_queue.sv
hw/rtl/rx_frame_deframer_top.sv
test/rx_frame_deframer_checker.sv
test/rx_frame_deframer_top_tb.sv
